// ===== rtl/ctfl_pkg.sv =====
// shared types, constants and helpers of the connection table
package ctfl_pkg;

  localparam int unsigned DefTableEntries  = 64;
  localparam int unsigned DefProtocolCount = 4;
  localparam int unsigned DefIdWidth       = $clog2(DefTableEntries);
  localparam int unsigned DefCntWidth      = $clog2(DefTableEntries + 1);

  localparam int unsigned OpWidth     = 2;
  localparam int unsigned ProtoWidth  = 2;
  localparam int unsigned AddrWidth   = 32;
  localparam int unsigned PortWidth   = 16;
  localparam int unsigned StatusWidth = 2;

  localparam logic [AddrWidth-1:0] WildAddr = '1;
  localparam logic [PortWidth-1:0] WildPort = '1;

  typedef enum logic [OpWidth-1:0] {
    OpAlloc   = 2'd0,
    OpFind    = 2'd1,
    OpRelease = 2'd2
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2,
    StNotInUse = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StAllocRd,
    StAllocOld,
    StFind,
    StRelRd,
    StRelNext,
    StRelPrev,
    StRelFree,
    StRelTail,
    StResp
  } state_e;

  // protocol code folded into the range of the configured protocol count
  function automatic logic [ProtoWidth-1:0] proto_fold(logic [ProtoWidth-1:0] p,
                                                        int unsigned count);
    logic [ProtoWidth-1:0] v;
    v = p;
    for (int k = 0; k < (2 ** ProtoWidth) - 1; k++) begin
      if (int'(v) >= count) v = v - ProtoWidth'(count);
    end
    return v;
  endfunction

endpackage

// ===== rtl/ctfl_if.sv =====
// request and response channel interfaces of the connection table
interface ctfl_req_if #(
  parameter int unsigned IdW = ctfl_pkg::DefIdWidth
) ();
  import ctfl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OpWidth-1:0]    op;
  logic [ProtoWidth-1:0] protocol;
  logic [AddrWidth-1:0]  remote_addr;
  logic [PortWidth-1:0]  remote_port;
  logic [IdW-1:0]        conn_id;

  modport source (output valid, op, protocol, remote_addr, remote_port, conn_id,
                  input ready);
  modport sink (input valid, op, protocol, remote_addr, remote_port, conn_id,
                output ready);
endinterface

interface ctfl_rsp_if #(
  parameter int unsigned IdW  = ctfl_pkg::DefIdWidth,
  parameter int unsigned CntW = ctfl_pkg::DefCntWidth
) ();
  import ctfl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StatusWidth-1:0] status;
  logic [IdW-1:0]         result_id;
  logic [CntW-1:0]        free_count;

  modport source (output valid, status, result_id, free_count, input ready);
  modport sink (input valid, status, result_id, free_count, output ready);
endinterface

// ===== rtl/ctfl_ram.sv =====
// generic single write port ram with registered read
module ctfl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/connection_table_with_free_list.sv =====
// connection table top level: entry store, free list and per-protocol lists
//
// A table of TABLE_ENTRIES connection entries. Free entries form a FIFO free
// list (allocate takes its head, release appends at its tail); each used entry
// holds protocol, remote address and remote port and is pushed at the head of
// its protocol's doubly linked list. Find walks that list newest to oldest and
// returns the first entry whose stored port and address match, a stored
// all-ones value matching anything. Entry data lives in one ram and the
// prev/next links in a second; both have a registered read, so every link
// update is a read followed by a write and the sequencer orders the steps so
// that no read ever overlaps a pending write of the same entry. One request is
// worked on at a time. The find walk visits at most TABLE_ENTRIES entries, the
// link ram delivering one entry per cycle. A finished response waits in an
// output register, loading the next one waits while an earlier response there
// is still unaccepted, and the block is ready for the next request in the
// cycle after the response is loaded. After reset the block sweeps both rams
// to build the initial free list before the first request is accepted.
module connection_table_with_free_list #(
  parameter int unsigned TABLE_ENTRIES  = ctfl_pkg::DefTableEntries,
  parameter int unsigned PROTOCOL_COUNT = ctfl_pkg::DefProtocolCount
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctfl_req_if.sink   req_i,
  ctfl_rsp_if.source rsp_o
);
  import ctfl_pkg::*;

  // widths: entry index, link (entry index or null), protocol list index
  localparam int unsigned IdW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned LinkW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PW    = (PROTOCOL_COUNT > 1) ? $clog2(PROTOCOL_COUNT) : 1;

  // null link is the table size
  localparam logic [LinkW-1:0] Nil     = LinkW'(TABLE_ENTRIES);
  localparam logic [IdW-1:0]   LastIdx = IdW'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic                 used;
    logic [PW-1:0]        proto;
    logic [AddrWidth-1:0] addr;
    logic [PortWidth-1:0] port;
  } node_t;

  typedef struct packed {
    logic [LinkW-1:0] prev;
    logic [LinkW-1:0] next;
  } link_t;

  function automatic logic is_entry(logic [LinkW-1:0] x);
    return x < Nil;
  endfunction

  function automatic logic [IdW-1:0] idx(logic [LinkW-1:0] x);
    return x[IdW-1:0];
  endfunction

  // sequencer and free list state
  state_e            state_q, state_d;
  logic [IdW-1:0]    clr_q, clr_d;
  logic [LinkW-1:0]  free_head_q, free_head_d;
  logic [LinkW-1:0]  free_tail_q, free_tail_d;
  logic [LinkW-1:0]  free_cnt_q, free_cnt_d;
  logic [LinkW-1:0]  list_head_q [PROTOCOL_COUNT];
  logic [LinkW-1:0]  list_head_d [PROTOCOL_COUNT];

  // request being worked on
  logic [PW-1:0]        proto_q, proto_d;
  logic [AddrWidth-1:0] addr_q, addr_d;
  logic [PortWidth-1:0] port_q, port_d;
  logic [IdW-1:0]       cur_q, cur_d;     // entry allocated, visited or released
  logic [LinkW-1:0]     p_q, p_d;         // neighbors of a released entry, or old head
  logic [LinkW-1:0]     n_q, n_d;
  logic [LinkW-1:0]     steps_q, steps_d; // entries visited by the find walk
  status_e              res_status_q, res_status_d;
  logic [IdW-1:0]       res_id_q, res_id_d;

  // response register
  logic             rsp_valid_q, rsp_valid_d;
  status_e          rsp_status_q, rsp_status_d;
  logic [IdW-1:0]   rsp_id_q, rsp_id_d;
  logic [LinkW-1:0] rsp_cnt_q, rsp_cnt_d;

  // ram ports
  logic           a_we, b_we;
  logic [IdW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  node_t          a_wdata, a_rdata;
  link_t          b_wdata, b_rdata;

  // request decode
  op_e           req_op;
  logic [PW-1:0] req_proto;
  logic          req_fire;
  logic          alloc_ok;
  logic          cid_ok;
  logic          find_match;
  logic          resp_load;

  assign req_op    = op_e'(req_i.op);
  assign req_proto = PW'(proto_fold(req_i.protocol, PROTOCOL_COUNT));
  assign req_fire  = req_i.valid && req_i.ready;
  assign alloc_ok  = (free_cnt_q != '0) && is_entry(free_head_q);
  assign cid_ok    = LinkW'(req_i.conn_id) < Nil;
  assign resp_load = (state_q == StResp) && (!rsp_valid_q || rsp_o.ready);

  // stored all-ones acts as wildcard on either field
  assign find_match = ((a_rdata.port == WildPort) || (a_rdata.port == port_q)) &&
                      ((a_rdata.addr == WildAddr) || (a_rdata.addr == addr_q));

  assign req_i.ready = (state_q == StIdle);

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.result_id  = rsp_id_q;
  assign rsp_o.free_count = rsp_cnt_q;

  // entry data ram: used flag, protocol, remote address and port
  ctfl_ram #(
    .Width ($bits(node_t)),
    .Depth (TABLE_ENTRIES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  // link ram: prev and next of every entry, shared by free and protocol lists
  ctfl_ram #(
    .Width ($bits(link_t)),
    .Depth (TABLE_ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_q == LastIdx) state_d = StIdle;
      end
      StIdle: begin
        if (req_fire) begin
          case (req_op)
            OpAlloc:   state_d = alloc_ok ? StAllocRd : StResp;
            OpFind:    state_d = is_entry(list_head_q[req_proto]) ? StFind : StResp;
            OpRelease: state_d = cid_ok ? StRelRd : StResp;
            default:   state_d = StResp;
          endcase
        end
      end
      StAllocRd: begin
        state_d = is_entry(list_head_q[proto_q]) ? StAllocOld : StResp;
      end
      StAllocOld: state_d = StResp;
      StFind: begin
        if (find_match || !is_entry(b_rdata.next) || (steps_q == Nil)) begin
          state_d = StResp;
        end
      end
      StRelRd: begin
        if (!a_rdata.used) begin
          state_d = StResp;
        end else if (is_entry(b_rdata.next)) begin
          state_d = StRelNext;
        end else if (is_entry(b_rdata.prev)) begin
          state_d = StRelPrev;
        end else begin
          state_d = StRelFree;
        end
      end
      StRelNext: state_d = is_entry(p_q) ? StRelPrev : StRelFree;
      StRelPrev: state_d = StRelFree;
      StRelFree: begin
        state_d = ((free_cnt_q == '0) || !is_entry(free_tail_q)) ? StResp : StRelTail;
      end
      StRelTail: state_d = StResp;
      StResp: begin
        if (!rsp_valid_q || rsp_o.ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and ram accesses
  always_comb begin
    clr_d        = clr_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    free_cnt_d   = free_cnt_q;
    list_head_d  = list_head_q;
    proto_d      = proto_q;
    addr_d       = addr_q;
    port_d       = port_q;
    cur_d        = cur_q;
    p_d          = p_q;
    n_d          = n_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    rsp_status_d = rsp_status_q;
    rsp_id_d     = rsp_id_q;
    rsp_cnt_d    = rsp_cnt_q;
    rsp_valid_d  = rsp_o.ready ? 1'b0 : rsp_valid_q;

    a_we    = 1'b0;
    a_waddr = cur_q;
    a_wdata = '0;
    a_raddr = cur_q;
    b_we    = 1'b0;
    b_waddr = cur_q;
    b_wdata = '0;
    b_raddr = cur_q;

    case (state_q)
      StClear: begin
        // initial free list: every entry unused, chained in index order
        clr_d   = clr_q + IdW'(1);
        a_we    = 1'b1;
        a_waddr = clr_q;
        b_we    = 1'b1;
        b_waddr = clr_q;
        b_wdata = '{prev: Nil,
                    next: (clr_q == LastIdx) ? Nil : (LinkW'(clr_q) + LinkW'(1))};
      end
      StIdle: begin
        if (req_fire) begin
          proto_d      = req_proto;
          addr_d       = req_i.remote_addr;
          port_d       = req_i.remote_port;
          res_status_d = StOk;
          res_id_d     = '0;
          case (req_op)
            OpAlloc: begin
              if (alloc_ok) begin
                cur_d    = idx(free_head_q);
                res_id_d = idx(free_head_q);
                b_raddr  = idx(free_head_q);
              end else begin
                res_status_d = StFull;
              end
            end
            OpFind: begin
              if (is_entry(list_head_q[req_proto])) begin
                cur_d   = idx(list_head_q[req_proto]);
                a_raddr = idx(list_head_q[req_proto]);
                b_raddr = idx(list_head_q[req_proto]);
                steps_d = LinkW'(1);
              end else begin
                res_status_d = StNotFound;
              end
            end
            OpRelease: begin
              if (cid_ok) begin
                cur_d   = req_i.conn_id;
                a_raddr = req_i.conn_id;
                b_raddr = req_i.conn_id;
              end else begin
                res_status_d = StNotInUse;
              end
            end
            default: ;
          endcase
        end
      end
      StAllocRd: begin
        // take the free head, push the entry in front of its protocol list
        free_cnt_d = free_cnt_q - LinkW'(1);
        if (free_cnt_q == LinkW'(1)) begin
          free_head_d = Nil;
          free_tail_d = Nil;
        end else begin
          free_head_d = b_rdata.next;
        end
        a_we    = 1'b1;
        a_wdata = '{used: 1'b1, proto: proto_q, addr: addr_q, port: port_q};
        b_we    = 1'b1;
        b_wdata = '{prev: Nil, next: list_head_q[proto_q]};
        n_d     = list_head_q[proto_q];
        b_raddr = idx(list_head_q[proto_q]);
        list_head_d[proto_q] = LinkW'(cur_q);
      end
      StAllocOld: begin
        // old list head now points back at the new entry
        b_we    = 1'b1;
        b_waddr = idx(n_q);
        b_wdata = '{prev: LinkW'(cur_q), next: b_rdata.next};
      end
      StFind: begin
        if (find_match) begin
          res_status_d = StOk;
          res_id_d     = cur_q;
        end else if (!is_entry(b_rdata.next) || (steps_q == Nil)) begin
          res_status_d = StNotFound;
          res_id_d     = '0;
        end else begin
          cur_d   = idx(b_rdata.next);
          a_raddr = idx(b_rdata.next);
          b_raddr = idx(b_rdata.next);
          steps_d = steps_q + LinkW'(1);
        end
      end
      StRelRd: begin
        if (!a_rdata.used) begin
          res_status_d = StNotInUse;
        end else begin
          p_d     = b_rdata.prev;
          n_d     = b_rdata.next;
          proto_d = a_rdata.proto;
          a_we    = 1'b1;
          b_we    = 1'b1;
          b_wdata = '{prev: Nil, next: Nil};
          if (!is_entry(b_rdata.prev)) begin
            list_head_d[a_rdata.proto] = b_rdata.next;
          end
          b_raddr = is_entry(b_rdata.next) ? idx(b_rdata.next) : idx(b_rdata.prev);
        end
      end
      StRelNext: begin
        b_we    = 1'b1;
        b_waddr = idx(n_q);
        b_wdata = '{prev: p_q, next: b_rdata.next};
        b_raddr = idx(p_q);
      end
      StRelPrev: begin
        b_we    = 1'b1;
        b_waddr = idx(p_q);
        b_wdata = '{prev: b_rdata.prev, next: n_q};
      end
      StRelFree: begin
        // append to the free list tail, or restart an empty free list
        free_cnt_d = free_cnt_q + LinkW'(1);
        if ((free_cnt_q == '0) || !is_entry(free_tail_q)) begin
          free_head_d = LinkW'(cur_q);
          free_tail_d = LinkW'(cur_q);
        end else begin
          b_raddr = idx(free_tail_q);
        end
      end
      StRelTail: begin
        b_we        = 1'b1;
        b_waddr     = idx(free_tail_q);
        b_wdata     = '{prev: b_rdata.prev, next: LinkW'(cur_q)};
        free_tail_d = LinkW'(cur_q);
      end
      StResp: begin
        if (resp_load) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_id_d     = res_id_q;
          rsp_cnt_d    = free_cnt_q;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      free_head_q <= '0;
      free_tail_q <= LinkW'(TABLE_ENTRIES - 1);
      free_cnt_q  <= Nil;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < PROTOCOL_COUNT; i++) begin
        list_head_q[i] <= Nil;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_head_q <= free_head_d;
      free_tail_q <= free_tail_d;
      free_cnt_q  <= free_cnt_d;
      rsp_valid_q <= rsp_valid_d;
      list_head_q <= list_head_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    proto_q      <= proto_d;
    addr_q       <= addr_d;
    port_q       <= port_d;
    cur_q        <= cur_d;
    p_q          <= p_d;
    n_q          <= n_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    rsp_status_q <= rsp_status_d;
    rsp_id_q     <= rsp_id_d;
    rsp_cnt_q    <= rsp_cnt_d;
  end

`ifndef SYNTH
  // free count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= Nil)
    else $error("free count exceeds table size");

  // an empty free list and a null free head go together between requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> ((free_cnt_q == '0) == (free_head_q == Nil)))
    else $error("free head and free count disagree");

  // failed requests report entry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q != StOk)) |-> (rsp_id_q == '0))
    else $error("nonzero id on failed request");

  // find walk visits at least one and at most all entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFind) |-> ((steps_q != '0) && (steps_q <= Nil)))
    else $error("find walk step count out of range");

  // a released entry always returns one free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRelFree) |=> (free_cnt_q == $past(free_cnt_q) + LinkW'(1)))
    else $error("release did not return a free entry");
`endif

endmodule
